>>> design/sbc_pkg.sv
// Shared types, register indexes and helpers for the segment/box clipper.
package sbc_pkg;

  localparam int QDepth  = 4;
  localparam int QIdxW   = $clog2(QDepth);
  localparam int DivBits = 31;

  typedef enum logic [2:0] {
    CFG_START_X    = 3'd0,
    CFG_START_Y    = 3'd1,
    CFG_START_Z    = 3'd2,
    CFG_DIR_X      = 3'd3,
    CFG_DIR_Y      = 3'd4,
    CFG_DIR_Z      = 3'd5,
    CFG_SEG_LENGTH = 3'd6
  } sbc_cfg_idx_e;

  typedef struct packed {
    logic [2:0][31:0] start;
    logic [2:0][17:0] dir;
    logic [30:0]      len;
  } sbc_cfg_t;

  // one divide request: |N| split into the initial remainder and the bits still to shift in
  typedef struct packed {
    logic [17:0] hi;
    logic [30:0] lo;
    logic        neg;
    logic        ovf;
  } sbc_div_req_t;

  typedef struct packed {
    sbc_div_req_t [5:0] bnd;
    logic [2:0]         miss;
  } sbc_item_t;

  function automatic logic [17:0] dir_mag(logic [17:0] d);
    dir_mag = d[17] ? 18'(-d) : d;
  endfunction

endpackage

>>> design/sbc_front.sv
// Front end: turns a box request into divide requests and per-axis flat-slab misses.
module sbc_front (
  input  sbc_pkg::sbc_cfg_t  cfg_i,
  input  logic [191:0]       box_i,
  output sbc_pkg::sbc_item_t item_o
);
  import sbc_pkg::*;

  logic [2:0][17:0] dmag;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic [31:0] lo_b, hi_b, s;
    assign lo_b = box_i[64*k +: 32];
    assign hi_b = box_i[64*k+32 +: 32];
    assign s    = cfg_i.start[k];
    assign dmag[k] = dir_mag(cfg_i.dir[k]);
    assign item_o.miss[k] = (cfg_i.dir[k] == 18'd0) &&
                            (($signed(s) < $signed(lo_b)) || ($signed(s) > $signed(hi_b)));
  end

  for (genvar i = 0; i < 6; i++) begin : g_bnd
    localparam int K = i / 2;
    logic [31:0] b, s;
    logic [32:0] diff, amag;
    logic [48:0] nmag;
    assign b    = box_i[32*i +: 32];
    assign s    = cfg_i.start[K];
    assign diff = {b[31], b} - {s[31], s};
    assign amag = diff[32] ? 33'(-diff) : diff;
    assign nmag = {amag, 16'h0000};
    assign item_o.bnd[i].hi  = nmag[48:31];
    assign item_o.bnd[i].lo  = nmag[30:0];
    assign item_o.bnd[i].neg = diff[32] ^ cfg_i.dir[K][17];
    assign item_o.bnd[i].ovf = nmag[48:31] >= dmag[K];
  end

endmodule

>>> design/sbc_queue.sv
// Small FIFO between the front end and the back end.
module sbc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sbc_pkg::sbc_item_t data_i,
  output logic               ready_o,
  input  logic               pop_i,
  output logic               valid_o,
  output sbc_pkg::sbc_item_t data_o
);
  import sbc_pkg::*;

  sbc_item_t      ent_q [QDepth];
  sbc_item_t      nxt [QDepth];
  logic [QIdxW:0] cnt_q, cnt_d, slot;
  logic           do_push, do_pop;

  assign ready_o = cnt_q != (QIdxW+1)'(QDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = ent_q[0];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    slot  = cnt_q - (QIdxW+1)'(do_pop);
    cnt_d = cnt_q + (QIdxW+1)'(do_push) - (QIdxW+1)'(do_pop);
  end

  // entries move towards the head on a pop; a push lands in the first free slot
  always_comb begin
    for (int i = 0; i < QDepth - 1; i++) begin
      nxt[i] = ent_q[i+1];
    end
    nxt[QDepth-1] = ent_q[QDepth-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      if (do_push && slot == (QIdxW+1)'(i)) begin
        ent_q[i] <= data_i;
      end else if (do_pop) begin
        ent_q[i] <= nxt[i];
      end
    end
  end

endmodule

>>> design/sbc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module sbc_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [17:0] hi_i,
  input  logic [30:0] lo_i,
  input  logic [17:0] dmag_i,
  output logic [30:0] q_o
);
  import sbc_pkg::*;

  logic [DivBits-1:0][17:0] rem_q;
  logic [DivBits-1:0][30:0] num_q;
  logic [DivBits-1:0][30:0] quo_q;

  for (genvar j = 0; j < DivBits; j++) begin : g_stage
    logic [17:0] rem_in;
    logic [30:0] num_in, quo_in;
    logic [18:0] shf;
    logic        ge;
    if (j == 0) begin : g_first
      assign rem_in = hi_i;
      assign num_in = lo_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign num_in = num_q[j-1];
      assign quo_in = quo_q[j-1];
    end
    assign shf = {rem_in, num_in[30]};
    assign ge  = shf >= {1'b0, dmag_i};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? 18'(shf - {1'b0, dmag_i}) : shf[17:0];
        num_q[j] <= {num_in[29:0], 1'b0};
        quo_q[j] <= {quo_in[29:0], ge};
      end
    end
  end

  assign q_o = quo_q[DivBits-1];

endmodule

>>> design/sbc_back.sv
// Back end: slab divides, clipping, point evaluation and the result register.
module sbc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbc_pkg::sbc_cfg_t  cfg_i,
  input  sbc_pkg::sbc_item_t item_i,
  input  logic               item_valid_i,
  output logic               item_pop_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [191:0]       m_tdata_o,
  output logic               m_tuser_o
);
  import sbc_pkg::*;

  logic en;
  logic out_vld_q, vld_c_q, vld_m_q;
  logic [DivBits-1:0]       vld_q;
  logic [DivBits-1:0][14:0] side_q;
  logic [14:0]              side_in;
  logic [5:0][30:0]         quo;
  logic [2:0][17:0]         dmag;

  assign en         = !out_vld_q || m_tready_i;
  assign item_pop_o = en;
  assign m_tvalid_o = out_vld_q;

  for (genvar k = 0; k < 3; k++) begin : g_dmag
    assign dmag[k] = dir_mag(cfg_i.dir[k]);
  end

  for (genvar i = 0; i < 6; i++) begin : g_div
    localparam int K = i / 2;
    assign side_in[3+i] = item_i.bnd[i].neg;
    assign side_in[9+i] = item_i.bnd[i].ovf;
    sbc_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .hi_i  (item_i.bnd[i].hi),
      .lo_i  (item_i.bnd[i].lo),
      .dmag_i(dmag[K]),
      .q_o   (quo[i])
    );
  end
  assign side_in[2:0] = item_i.miss;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q <= {side_q[DivBits-2:0], side_in};
    end
  end

  // clip stage
  logic [14:0]      side;
  logic [5:0][33:0] t;
  logic [2:0]       rej;
  logic [2:0][30:0] ta, tb;
  logic [30:0]      tin, tout;
  logic [33:0]      len_w;

  assign side  = side_q[DivBits-1];
  assign len_w = {3'b000, cfg_i.len};

  for (genvar i = 0; i < 6; i++) begin : g_t
    logic [33:0] mag;
    assign mag  = side[9+i] ? 34'h0_8000_0000 : {3'b000, quo[i]};
    assign t[i] = side[3+i] ? 34'(-mag) : mag;
  end

  for (genvar k = 0; k < 3; k++) begin : g_clip
    logic [33:0] a, b;
    logic        dz, dn;
    assign dz = cfg_i.dir[k] == 18'd0;
    assign dn = cfg_i.dir[k][17];
    assign a  = dz ? 34'd0 : (dn ? t[2*k+1] : t[2*k]);
    assign b  = dz ? len_w : (dn ? t[2*k] : t[2*k+1]);
    assign rej[k] = side[k] || (a[33] && b[33]) ||
                    (($signed(a) > $signed(len_w)) && ($signed(b) > $signed(len_w)));
    assign ta[k] = a[33] ? 31'd0 : ($signed(a) > $signed(len_w) ? cfg_i.len : a[30:0]);
    assign tb[k] = b[33] ? 31'd0 : ($signed(b) > $signed(len_w) ? cfg_i.len : b[30:0]);
  end

  always_comb begin
    tin = ta[0];
    if (ta[1] > tin) tin = ta[1];
    if (ta[2] > tin) tin = ta[2];
    tout = tb[0];
    if (tb[1] < tout) tout = tb[1];
    if (tb[2] < tout) tout = tb[2];
  end

  logic        hit_c_q, hit_m_q, hit_o_q;
  logic [30:0] tin_q, tout_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_c_q <= (rej == 3'b000) && (tin <= tout);
      tin_q   <= tin;
      tout_q  <= tout;
    end
  end

  // multiply stage
  logic signed [5:0][49:0] prod_q;
  logic [5:0][49:0]        prod;
  for (genvar j = 0; j < 6; j++) begin : g_mul
    localparam int K = j % 3;
    logic [30:0] tt;
    assign tt      = (j < 3) ? tin_q : tout_q;
    assign prod[j] = $signed(cfg_i.dir[K]) * $signed({1'b0, tt});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q  <= prod;
      hit_m_q <= hit_c_q;
    end
  end

  // round, add start, saturate
  logic [5:0][31:0] pt;
  logic [191:0]     data_q;
  for (genvar j = 0; j < 6; j++) begin : g_pt
    localparam int K = j % 3;
    logic [49:0] r;
    logic [33:0] qv;
    logic [34:0] v;
    logic [31:0] s;
    assign s  = cfg_i.start[K];
    assign r  = prod_q[j] + 50'd32768;
    assign qv = r[49:16];
    assign v  = {{3{s[31]}}, s} + {qv[33], qv};
    assign pt[j] = (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) ? v[31:0] :
                   (v[34] ? 32'h8000_0000 : 32'h7FFF_FFFF);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q  <= hit_m_q ? pt : '0;
      hit_o_q <= hit_m_q;
    end
  end

  assign m_tdata_o = data_q;
  assign m_tuser_o = hit_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_c_q   <= 1'b0;
      vld_m_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[DivBits-2:0], item_valid_i};
      vld_c_q   <= vld_q[DivBits-1];
      vld_m_q   <= vld_c_q;
      out_vld_q <= vld_m_q;
    end
  end

endmodule

>>> design/segment_box_clip.sv
// Top level: configuration registers, front end, queue and back end of the clipper.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//   s_axis    in         tvalid/tready           six box bounds
//   m_axis    out        tvalid/tready           hit, entry and exit points
//
// One request per cycle while results are taken; a request passes the queue, the 31-stage divide,
// clip, multiply and the result register.
// Reset clears the queue, the pipeline valids and the configuration registers to zero.
// A stalled result holds the whole back end; the queue keeps taking requests until full.
module segment_box_clip (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // box_x_min, box_x_max, box_y_min, box_y_max, box_z_min, box_z_max
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // entry_x, entry_y, entry_z, exit_x, exit_y, exit_z
  output logic [191:0] m_axis_tdata,
  // hit
  output logic         m_axis_tuser
);
  import sbc_pkg::*;

  sbc_cfg_t  cfg_q;
  sbc_item_t item_f, item_b;
  logic      q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (sbc_cfg_idx_e'(cfg_index_i))
        CFG_START_X:    cfg_q.start[0] <= cfg_data_i;
        CFG_START_Y:    cfg_q.start[1] <= cfg_data_i;
        CFG_START_Z:    cfg_q.start[2] <= cfg_data_i;
        CFG_DIR_X:      cfg_q.dir[0]   <= cfg_data_i[17:0];
        CFG_DIR_Y:      cfg_q.dir[1]   <= cfg_data_i[17:0];
        CFG_DIR_Z:      cfg_q.dir[2]   <= cfg_data_i[17:0];
        CFG_SEG_LENGTH: cfg_q.len      <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  sbc_front u_front (
    .cfg_i (cfg_q),
    .box_i (s_axis_tdata),
    .item_o(item_f)
  );

  sbc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s_axis_tvalid),
    .data_i (item_f),
    .ready_o(s_axis_tready),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (item_b)
  );

  sbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (item_b),
    .item_valid_i(q_valid),
    .item_pop_o  (q_pop),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule
